FILE: rtl/htvl_pkg.sv
// -----------------------------------------------------------------------------
// htvl_pkg : heading tracking velocity law, shared types and constants
// Fixed-point widths, CORDIC cell data words, arctangent table, saturation.
// -----------------------------------------------------------------------------
package htvl_pkg;

  // word widths
  localparam int unsigned VEC_W = 36;  // vectoring x/y
  localparam int unsigned ZV_W  = 20;  // vectoring angle accumulator
  localparam int unsigned ROT_W = 33;  // rotation x/y, Q2.30
  localparam int unsigned ZR_W  = 21;  // rotation angle
  localparam int unsigned ANG_W = 21;  // heading error
  localparam int unsigned CS_W  = 19;  // cos/sin, Q2.16
  localparam int unsigned SX_W  = 38;  // gained position error
  localparam int unsigned W_W   = 22;  // sliding angular term
  localparam int unsigned WIDE_W = 50; // pre-saturation result

  localparam logic signed [ANG_W-1:0] PI_Q      = 21'sd205887;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q = 21'sd102944;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q  = 21'sd411775;
  localparam logic signed [ANG_W-1:0] BOUNDARY_Q = 21'sd9830;
  localparam logic [13:0] NEAR_Q = 14'd6554;
  localparam logic [28:0] NEAR_SQ_Q = 29'd42954916;
  localparam logic [21:0] SMALL_W_Q = 22'd655;
  localparam logic [16:0] ONE_Q = 17'd65536;
  localparam logic signed [ROT_W-1:0] GAIN_INV_Q30 = 33'sd652032874;
  // ceil(2^40 / 9830), reciprocal for the boundary layer divide
  localparam logic [26:0] RECIP_M = 27'd111852658;
  localparam logic [13:0] BOUNDARY_U = 14'd9830;

  // register indices
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_MAX_LIN = 3'd1;
  localparam logic [2:0] REG_MAX_ANG = 3'd2;
  localparam logic [2:0] REG_MIN_ANG = 3'd3;
  localparam logic [2:0] REG_GAIN    = 3'd4;
  localparam logic [2:0] REG_INV_OFF = 3'd5;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ZV_W-1:0]  z;
  } vec_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ZR_W-1:0]  z;
    logic                    neg;
  } rot_t;

  // side data riding along the vectoring chain
  typedef struct packed {
    logic                    near;
    logic signed [SX_W-1:0]  sx;
    logic signed [SX_W-1:0]  sy;
    logic signed [18:0]      h;
  } vside_t;

  // side data riding along the rotation chain
  typedef struct packed {
    logic                    near;
    logic signed [SX_W-1:0]  sx;
    logic signed [SX_W-1:0]  sy;
    logic signed [W_W-1:0]   w;
  } rside_t;

  // atan(2^-i), Q1.16
  function automatic logic [16:0] atan_q(input int unsigned i);
    logic [16:0] r;
    case (i)
      0:       r = 17'd51472;
      1:       r = 17'd30386;
      2:       r = 17'd16055;
      3:       r = 17'd8150;
      4:       r = 17'd4091;
      5:       r = 17'd2047;
      6:       r = 17'd1024;
      7:       r = 17'd512;
      8:       r = 17'd256;
      9:       r = 17'd128;
      10:      r = 17'd64;
      11:      r = 17'd32;
      12:      r = 17'd16;
      13:      r = 17'd8;
      14:      r = 17'd4;
      15:      r = 17'd2;
      16:      r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [31:0] r;
    if (v > WIDE_W'(signed'(32'sh7FFFFFFF))) begin
      r = 32'sh7FFFFFFF;
    end else if (v < WIDE_W'(signed'(32'sh80000000))) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/heading_tracking_velocity_law.sv
// -----------------------------------------------------------------------------
// heading_tracking_velocity_law : pose to speed command, pipelined
// Vectoring CORDIC chain for the target bearing, heading error and boundary layer
// divide, rotation CORDIC chain for cos/sin, then gain, clamp and saturate stages.
//
//   channel   handshake                 payload
//   command   start / busy              robot_x/y, robot_heading, target_x/y
//   result    result_valid_o (strobe)   linear_command_o, angular_command_o
//   config    cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One word accepted every cycle; busy stays low.
// Each word passes stage A, the vectoring cell chain, stages E, D1 and D2, the rotation cell chain, F1 to F3, output.
// Result strobed for one cycle; the receiver cannot stall.
// Reset clears the valid pipe and loads register defaults.
// -----------------------------------------------------------------------------
module heading_tracking_velocity_law #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] robot_x_i,
  input  logic signed [31:0] robot_y_i,
  input  logic signed [18:0] robot_heading_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  output logic               result_valid_o,
  output logic signed [31:0] linear_command_o,
  output logic signed [31:0] angular_command_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [22:0]        cfg_data_i
);

  localparam int unsigned N = CORDIC_STEPS;

  // configuration
  logic        mode_q;
  logic [19:0] max_lin_q, max_ang_q, min_ang_q, gain_q;
  logic [22:0] inv_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      max_lin_q <= 20'd32768;
      max_ang_q <= 20'd65536;
      min_ang_q <= 20'd0;
      gain_q    <= 20'd65536;
      inv_off_q <= 23'd327680;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        htvl_pkg::REG_MODE:    mode_q    <= cfg_data_i[0];
        htvl_pkg::REG_MAX_LIN: max_lin_q <= cfg_data_i[19:0];
        htvl_pkg::REG_MAX_ANG: max_ang_q <= cfg_data_i[19:0];
        htvl_pkg::REG_MIN_ANG: min_ang_q <= cfg_data_i[19:0];
        htvl_pkg::REG_GAIN:    gain_q    <= cfg_data_i[19:0];
        htvl_pkg::REG_INV_OFF: inv_off_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // ---------------- stage A: offsets ----------------
  logic               va_q;
  logic signed [32:0] dx_q, dy_q;
  logic signed [18:0] h_q;

  // ---------------- vectoring chain ----------------
  htvl_pkg::vec_t  vec_s [N+1];
  htvl_pkg::vside_t vside_d;
  htvl_pkg::vside_t vside_q [N];
  logic [N-1:0]    vv_q;

  logic in_x, in_y;
  logic signed [13:0] dx_s, dy_s;
  logic [28:0] d2;
  logic signed [53:0] kdx, kdy;

  assign in_x = (dx_q > -33'sd6554) && (dx_q < 33'sd6554);
  assign in_y = (dy_q > -33'sd6554) && (dy_q < 33'sd6554);
  assign dx_s = dx_q[13:0];
  assign dy_s = dy_q[13:0];
  assign d2 = 29'(unsigned'(28'(dx_s * dx_s))) + 29'(unsigned'(28'(dy_s * dy_s)));
  assign kdx = signed'({1'b0, gain_q}) * dx_q;
  assign kdy = signed'({1'b0, gain_q}) * dy_q;

  always_comb begin
    vside_d.near = in_x && in_y && (d2 < htvl_pkg::NEAR_SQ_Q);
    vside_d.sx   = kdx[53:16];
    vside_d.sy   = kdy[53:16];
    vside_d.h    = h_q;
    if (dx_q < 0) begin
      if (dy_q >= 0) begin
        vec_s[0].x = htvl_pkg::VEC_W'(dy_q);
        vec_s[0].y = -htvl_pkg::VEC_W'(dx_q);
        vec_s[0].z = htvl_pkg::ZV_W'(htvl_pkg::HALF_PI_Q);
      end else begin
        vec_s[0].x = -htvl_pkg::VEC_W'(dy_q);
        vec_s[0].y = htvl_pkg::VEC_W'(dx_q);
        vec_s[0].z = -htvl_pkg::ZV_W'(htvl_pkg::HALF_PI_Q);
      end
    end else begin
      vec_s[0].x = htvl_pkg::VEC_W'(dx_q);
      vec_s[0].y = htvl_pkg::VEC_W'(dy_q);
      vec_s[0].z = '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    htvl_vec_cell #(.STEP(i)) u_cell (
      .clk_i (clk_i),
      .in_i  (vec_s[i]),
      .out_o (vec_s[i+1])
    );
  end

  // ---------------- stage E: heading error ----------------
  logic               ve_q;
  logic signed [htvl_pkg::ANG_W-1:0] e_d, e_raw, e_q, ang_q;
  logic [29:0]        n_q;
  logic               satp_q, satn_q, near_e_q;
  logic signed [htvl_pkg::SX_W-1:0] sx_e_q, sy_e_q;

  assign e_raw = htvl_pkg::ANG_W'(vec_s[N].z) - htvl_pkg::ANG_W'(vside_q[N-1].h);

  always_comb begin
    if (e_raw > htvl_pkg::PI_Q) begin
      e_d = e_raw - htvl_pkg::TWO_PI_Q;
    end else if (e_raw < -htvl_pkg::PI_Q) begin
      e_d = e_raw + htvl_pkg::TWO_PI_Q;
    end else begin
      e_d = e_raw;
    end
  end

  // ---------------- stages D1/D2: boundary layer divide ----------------
  logic               vd1_q, vd2_q;
  logic signed [htvl_pkg::ANG_W-1:0] e1_q, ang1_q, ang2_q;
  logic [29:0]        n1_q;
  logic [16:0]        q0_q;
  logic               satp1_q, satn1_q, near1_q, near2_q;
  logic signed [htvl_pkg::SX_W-1:0] sx1_q, sy1_q, sx2_q, sy2_q;
  logic signed [htvl_pkg::W_W-1:0]  w2_q, w2_d;
  logic [56:0]        recip_p;
  logic [30:0]        chk;
  logic [16:0]        q_fix;
  logic signed [htvl_pkg::W_W-1:0]  satv;

  assign recip_p = n_q * htvl_pkg::RECIP_M;
  assign chk     = q0_q * htvl_pkg::BOUNDARY_U;
  assign q_fix   = (chk > 31'(n1_q)) ? (q0_q - 17'd1) : q0_q;

  always_comb begin
    if (satp1_q) begin
      satv = htvl_pkg::W_W'(signed'({1'b0, htvl_pkg::ONE_Q}));
    end else if (satn1_q) begin
      satv = -htvl_pkg::W_W'(signed'({1'b0, htvl_pkg::ONE_Q}));
    end else if (e1_q < 0) begin
      satv = -htvl_pkg::W_W'(signed'({1'b0, q_fix}));
    end else begin
      satv = htvl_pkg::W_W'(signed'({1'b0, q_fix}));
    end
    w2_d = htvl_pkg::W_W'(e1_q) + htvl_pkg::W_W'(e1_q) + satv;
  end

  // ---------------- rotation chain ----------------
  htvl_pkg::rot_t   rot_s [N+1];
  htvl_pkg::rside_t rside_d;
  htvl_pkg::rside_t rside_q [N];
  logic [N-1:0]     rv_q;

  always_comb begin
    rot_s[0].x = htvl_pkg::GAIN_INV_Q30;
    rot_s[0].y = '0;
    if (ang2_q > htvl_pkg::HALF_PI_Q) begin
      rot_s[0].z   = ang2_q - htvl_pkg::PI_Q;
      rot_s[0].neg = 1'b1;
    end else if (ang2_q < -htvl_pkg::HALF_PI_Q) begin
      rot_s[0].z   = ang2_q + htvl_pkg::PI_Q;
      rot_s[0].neg = 1'b1;
    end else begin
      rot_s[0].z   = ang2_q;
      rot_s[0].neg = 1'b0;
    end
    rside_d.near = near2_q;
    rside_d.sx   = sx2_q;
    rside_d.sy   = sy2_q;
    rside_d.w    = w2_q;
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    htvl_rot_cell #(.STEP(i)) u_cell (
      .clk_i (clk_i),
      .in_i  (rot_s[i]),
      .out_o (rot_s[i+1])
    );
  end

  // ---------------- output stages ----------------
  logic signed [htvl_pkg::ROT_W-1:0] xf, yf;
  logic signed [htvl_pkg::CS_W-1:0]  c_s, s_s;

  assign xf  = rot_s[N].neg ? -rot_s[N].x : rot_s[N].x;
  assign yf  = rot_s[N].neg ? -rot_s[N].y : rot_s[N].y;
  assign c_s = xf[32:14];
  assign s_s = yf[32:14];

  logic               vf1_q, vf2_q, vf3_q;
  logic signed [56:0] pcx_q, psy_q, pcy_q, psx_q;
  logic signed [39:0] pv_q;
  logic               near_f1_q;
  logic signed [htvl_pkg::W_W-1:0] w_f1_q;

  logic signed [57:0] vsum, wsum;
  logic signed [23:0] vs_raw, vs;
  logic signed [htvl_pkg::W_W-1:0] ws0, ws, aw;
  logic signed [41:0] vm_q, wm_q;
  logic signed [htvl_pkg::W_W-1:0] ws_q;
  logic signed [23:0] vs_q;

  assign vsum   = 58'(pcx_q) + 58'(psy_q);
  assign wsum   = 58'(pcy_q) - 58'(psx_q);
  assign vs_raw = pv_q[39:16];

  always_comb begin
    vs  = near_f1_q ? '0 : vs_raw;
    ws0 = near_f1_q ? '0 : w_f1_q;
    if (vs < 0) begin
      vs = '0;
    end
    if (vs > 24'(signed'({1'b0, max_lin_q}))) begin
      vs = 24'(signed'({1'b0, max_lin_q}));
    end
    aw = (ws0 < 0) ? -ws0 : ws0;
    ws = ws0;
    priority if (aw > htvl_pkg::W_W'(signed'({1'b0, max_ang_q}))) begin
      ws = (ws0 < 0) ? -htvl_pkg::W_W'(signed'({1'b0, max_ang_q}))
                     : htvl_pkg::W_W'(signed'({1'b0, max_ang_q}));
    end else if (aw < htvl_pkg::W_W'(signed'({1'b0, min_ang_q}))
                 && aw > signed'(htvl_pkg::SMALL_W_Q)) begin
      ws = (ws0 < 0) ? -htvl_pkg::W_W'(signed'({1'b0, min_ang_q}))
                     : htvl_pkg::W_W'(signed'({1'b0, min_ang_q}));
    end else begin
      ws = ws0;
    end
  end

  logic signed [65:0] wprod;
  logic signed [htvl_pkg::WIDE_W-1:0] v3_q, w3_q, v3_d, w3_d;

  assign wprod = wm_q * signed'({1'b0, inv_off_q});

  always_comb begin
    if (mode_q) begin
      v3_d = htvl_pkg::WIDE_W'(vm_q);
      w3_d = wprod[65:16];
    end else begin
      v3_d = htvl_pkg::WIDE_W'(vs_q);
      w3_d = htvl_pkg::WIDE_W'(ws_q);
    end
  end

  logic               out_v_q;
  logic signed [31:0] lin_q, angc_q;

  // valid pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      vv_q    <= '0;
      ve_q    <= 1'b0;
      vd1_q   <= 1'b0;
      vd2_q   <= 1'b0;
      rv_q    <= '0;
      vf1_q   <= 1'b0;
      vf2_q   <= 1'b0;
      vf3_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      va_q    <= accept;
      vv_q    <= N'({vv_q, va_q});
      ve_q    <= vv_q[N-1];
      vd1_q   <= ve_q;
      vd2_q   <= vd1_q;
      rv_q    <= N'({rv_q, vd2_q});
      vf1_q   <= rv_q[N-1];
      vf2_q   <= vf1_q;
      vf3_q   <= vf2_q;
      out_v_q <= vf3_q;
    end
  end

  // payload pipe
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx_q <= 33'(target_x_i) - 33'(robot_x_i);
      dy_q <= 33'(target_y_i) - 33'(robot_y_i);
      h_q  <= robot_heading_i;
    end
    vside_q[0] <= vside_d;
    for (int i = 1; i < N; i++) begin
      vside_q[i] <= vside_q[i-1];
    end
    // stage E
    e_q      <= e_d;
    ang_q    <= mode_q ? htvl_pkg::ANG_W'(vside_q[N-1].h) : e_d;
    n_q      <= {unsigned'(14'((e_d < 0) ? -e_d : e_d)), 16'd0};
    satp_q   <= e_d > htvl_pkg::BOUNDARY_Q;
    satn_q   <= e_d < -htvl_pkg::BOUNDARY_Q;
    near_e_q <= vside_q[N-1].near;
    sx_e_q   <= vside_q[N-1].sx;
    sy_e_q   <= vside_q[N-1].sy;
    // stage D1
    q0_q    <= recip_p[56:40];
    n1_q    <= n_q;
    e1_q    <= e_q;
    ang1_q  <= ang_q;
    satp1_q <= satp_q;
    satn1_q <= satn_q;
    near1_q <= near_e_q;
    sx1_q   <= sx_e_q;
    sy1_q   <= sy_e_q;
    // stage D2
    w2_q    <= w2_d;
    ang2_q  <= ang1_q;
    near2_q <= near1_q;
    sx2_q   <= sx1_q;
    sy2_q   <= sy1_q;
    rside_q[0] <= rside_d;
    for (int i = 1; i < N; i++) begin
      rside_q[i] <= rside_q[i-1];
    end
    // stage F1: products
    pcx_q     <= c_s * rside_q[N-1].sx;
    psy_q     <= s_s * rside_q[N-1].sy;
    pcy_q     <= c_s * rside_q[N-1].sy;
    psx_q     <= s_s * rside_q[N-1].sx;
    pv_q      <= signed'({1'b0, max_lin_q}) * c_s;
    near_f1_q <= rside_q[N-1].near;
    w_f1_q    <= rside_q[N-1].w;
    // stage F2: rotate back, clamp
    vm_q <= vsum[57:16];
    wm_q <= wsum[57:16];
    vs_q <= vs;
    ws_q <= ws;
    // stage F3: front offset gain, mode select
    v3_q <= v3_d;
    w3_q <= w3_d;
    // output word
    lin_q  <= htvl_pkg::sat32(v3_q);
    angc_q <= htvl_pkg::sat32(w3_q);
  end

  assign result_valid_o    = out_v_q;
  assign linear_command_o  = lin_q;
  assign angular_command_o = angc_q;

endmodule

FILE: rtl/htvl_vec_cell.sv
// -----------------------------------------------------------------------------
// htvl_vec_cell : one vectoring CORDIC micro-rotation
// Drives y toward zero and accumulates the angle; registered output word.
// -----------------------------------------------------------------------------
module htvl_vec_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic            clk_i,
  input  htvl_pkg::vec_t  in_i,
  output htvl_pkg::vec_t  out_o
);

  htvl_pkg::vec_t out_d, out_q;
  logic signed [htvl_pkg::ZV_W-1:0] a;

  assign a = signed'(htvl_pkg::ZV_W'(htvl_pkg::atan_q(STEP)));

  always_comb begin
    if (in_i.y > 0) begin
      out_d.x = in_i.x + (in_i.y >>> STEP);
      out_d.y = in_i.y - (in_i.x >>> STEP);
      out_d.z = in_i.z + a;
    end else begin
      out_d.x = in_i.x - (in_i.y >>> STEP);
      out_d.y = in_i.y + (in_i.x >>> STEP);
      out_d.z = in_i.z - a;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o = out_q;

endmodule

FILE: rtl/htvl_rot_cell.sv
// -----------------------------------------------------------------------------
// htvl_rot_cell : one rotation CORDIC micro-rotation
// Turns the vector by the table angle, driving residual angle to zero.
// -----------------------------------------------------------------------------
module htvl_rot_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic            clk_i,
  input  htvl_pkg::rot_t  in_i,
  output htvl_pkg::rot_t  out_o
);

  htvl_pkg::rot_t out_d, out_q;
  logic signed [htvl_pkg::ZR_W-1:0] a;

  assign a = signed'(htvl_pkg::ZR_W'(htvl_pkg::atan_q(STEP)));

  always_comb begin
    out_d.neg = in_i.neg;
    if (in_i.z >= 0) begin
      out_d.x = in_i.x - (in_i.y >>> STEP);
      out_d.y = in_i.y + (in_i.x >>> STEP);
      out_d.z = in_i.z - a;
    end else begin
      out_d.x = in_i.x + (in_i.y >>> STEP);
      out_d.y = in_i.y - (in_i.x >>> STEP);
      out_d.z = in_i.z + a;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o = out_q;

endmodule

FILE: rtl/htvl_checker.sv
// -----------------------------------------------------------------------------
// htvl_port_checks : port-level checks for the velocity law pipeline
// Fixed latency from accepted command word to result strobe, no stalls.
// -----------------------------------------------------------------------------
module htvl_port_checks #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o,
  input logic cfg_we_i
);

  localparam int unsigned LAT = 2 * CORDIC_STEPS + 8;

  // count cycles since reset, saturate once the pipe has filled
  logic [$clog2(LAT+1)-1:0] cnt_q;
  logic                     filled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (!filled) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign filled = (cnt_q == ($clog2(LAT+1))'(LAT));

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled && $past(start && !busy, LAT) |-> result_valid_o)
    else $error("result word missing");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled && result_valid_o |-> $past(start && !busy, LAT))
    else $error("result word without command");

  a_cold_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q < ($clog2(LAT+1))'(LAT)) |-> !result_valid_o)
    else $error("result word before pipe filled");

  // hold register writes apart from command words
  a_cfg_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !(start && !busy))
    else $error("register write with command word");

endmodule

bind heading_tracking_velocity_law htvl_port_checks #(.CORDIC_STEPS(CORDIC_STEPS)) u_htvl_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .cfg_we_i       (cfg_we_i)
);
